// ----- rtl/cap_pkg.sv -----
package cap_pkg;

    localparam int unsigned COLOR_ZONES_DEF = 3;
    localparam int unsigned ZONE_SLOTS      = 3;
    localparam int unsigned PIXEL_W         = 32;
    localparam int unsigned COV_W           = 7;
    localparam int unsigned COLUMN_W        = 12;
    localparam int unsigned CHAN_W          = 8;
    localparam int unsigned WEIGHT_W        = 14;
    localparam int unsigned PROD_W          = 16;
    localparam int unsigned S_TDATA_W       = 64;
    localparam int unsigned M_TDATA_W       = 32;
    localparam int unsigned CFG_REGS        = 7;
    localparam int unsigned CFG_IDX_W       = $clog2(CFG_REGS);
    localparam int unsigned CFG_DATA_W      = 32;
    localparam int unsigned PIPE_STAGES     = 4;

    localparam int unsigned CFG_MODE        = 0;
    localparam int unsigned CFG_ZONE_BASE   = 1;

    localparam logic [PIXEL_W-1:0] ZONE_COLOR_RESET = 32'h0000_0000;
    localparam logic [PIXEL_W-1:0] ZONE_END_RESET   = 32'hffff_ffff;
    localparam logic [CHAN_W:0]    ALPHA_ONE        = 9'h100;

    typedef enum logic [1:0] {
        MODE_BODY   = 2'd0,
        MODE_BORDER = 2'd1,
        MODE_RING   = 2'd2,
        MODE_PASS   = 2'd3
    } mode_t;

    typedef struct packed {
        logic first;
        logic second;
    } cap_stage_en_t;

endpackage

// ----- rtl/cap_cfg_regs.sv -----
module cap_cfg_regs
    import cap_pkg::*;
#(
    parameter int unsigned COLOR_ZONES = COLOR_ZONES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output mode_t                 mode,
    output logic [PIXEL_W-1:0]    zone_color [COLOR_ZONES],
    output logic [PIXEL_W-1:0]    zone_end [COLOR_ZONES]
);

    mode_t              mode_reg, mode_next;
    logic [PIXEL_W-1:0] color_reg [COLOR_ZONES];
    logic [PIXEL_W-1:0] color_next [COLOR_ZONES];
    logic [PIXEL_W-1:0] end_reg [COLOR_ZONES];
    logic [PIXEL_W-1:0] end_next [COLOR_ZONES];

    always_comb begin
        mode_next  = mode_reg;
        color_next = color_reg;
        end_next   = end_reg;
        if (cfg_wr_en) begin
            if (cfg_addr == CFG_IDX_W'(CFG_MODE)) begin
                mode_next = mode_t'(cfg_wdata[1:0]);
            end
            for (int z = 0; z < COLOR_ZONES; z++) begin
                if (cfg_addr == CFG_IDX_W'(CFG_ZONE_BASE + 2 * z)) begin
                    color_next[z] = cfg_wdata[PIXEL_W-1:0];
                end
                if (cfg_addr == CFG_IDX_W'(CFG_ZONE_BASE + 2 * z + 1)) begin
                    end_next[z] = cfg_wdata[PIXEL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BODY;
            for (int z = 0; z < COLOR_ZONES; z++) begin
                color_reg[z] <= ZONE_COLOR_RESET;
                end_reg[z]   <= ZONE_END_RESET;
            end
        end else begin
            mode_reg  <= mode_next;
            color_reg <= color_next;
            end_reg   <= end_next;
        end
    end

    assign mode       = mode_reg;
    assign zone_color = color_reg;
    assign zone_end   = end_reg;

endmodule

// ----- rtl/cap_front.sv -----
module cap_front
    import cap_pkg::*;
#(
    parameter int unsigned COLOR_ZONES = COLOR_ZONES_DEF
) (
    input  logic                      aclk,
    input  cap_stage_en_t             en,
    input  mode_t                     mode,
    input  logic [PIXEL_W-1:0]        zone_color [COLOR_ZONES],
    input  logic [PIXEL_W-1:0]        zone_end [COLOR_ZONES],
    input  logic [PIXEL_W-1:0]        dest_pixel,
    input  logic [COV_W-1:0]          body_coverage,
    input  logic [COV_W-1:0]          border_coverage,
    input  logic [COLUMN_W-1:0]       column,
    output logic [PIXEL_W-1:0]        dest_out,
    output logic [3*CHAN_W-1:0]       color_rgb,
    output logic [CHAN_W-1:0]         alpha
);

    logic [PIXEL_W-1:0]  dest_a_reg, dest_a_next;
    logic [PIXEL_W-1:0]  color_a_reg, color_a_next;
    logic [WEIGHT_W-1:0] weight_a_reg, weight_a_next;
    logic [PIXEL_W-1:0]  dest_b_reg;
    logic [3*CHAN_W-1:0] rgb_b_reg, rgb_b_next;
    logic [CHAN_W-1:0]   alpha_b_reg, alpha_b_next;
    logic [WEIGHT_W-1:0] scaled;

    function automatic logic col_below(input logic [COLUMN_W-1:0] col,
                                       input logic [PIXEL_W-1:0] bound);
        return (|bound[PIXEL_W-1:COLUMN_W]) || (col < bound[COLUMN_W-1:0]);
    endfunction

    always_comb begin
        color_a_next = zone_color[COLOR_ZONES-1];
        for (int k = COLOR_ZONES - 1; k >= 1; k--) begin
            if (col_below(column, zone_end[k])) begin
                color_a_next = zone_color[k-1];
            end
        end
        if (col_below(column, zone_end[0])) begin
            color_a_next = zone_color[0];
        end
        dest_a_next = dest_pixel;
        unique case (mode)
            MODE_BODY:   weight_a_next = WEIGHT_W'(body_coverage);
            MODE_BORDER: weight_a_next = WEIGHT_W'(border_coverage);
            MODE_RING:   weight_a_next = WEIGHT_W'(border_coverage) - WEIGHT_W'(body_coverage);
            MODE_PASS:   weight_a_next = '0;
            default:     weight_a_next = '0;
        endcase
    end

    // The weight is kept modulo 2^14, which is all the alpha byte depends on.
    assign scaled = weight_a_reg * {{(WEIGHT_W-CHAN_W){1'b0}}, color_a_reg[PIXEL_W-1 -: CHAN_W]};
    assign alpha_b_next = scaled[WEIGHT_W-1 -: CHAN_W];
    assign rgb_b_next   = color_a_reg[3*CHAN_W-1:0];

    always_ff @(posedge aclk) begin
        if (en.first) begin
            dest_a_reg   <= dest_a_next;
            color_a_reg  <= color_a_next;
            weight_a_reg <= weight_a_next;
        end
        if (en.second) begin
            dest_b_reg  <= dest_a_reg;
            rgb_b_reg   <= rgb_b_next;
            alpha_b_reg <= alpha_b_next;
        end
    end

    assign dest_out  = dest_b_reg;
    assign color_rgb = rgb_b_reg;
    assign alpha     = alpha_b_reg;

endmodule

// ----- rtl/cap_mix.sv -----
module cap_mix
    import cap_pkg::*;
(
    input  logic                aclk,
    input  cap_stage_en_t       en,
    input  logic [PIXEL_W-1:0]  dest_pixel,
    input  logic [3*CHAN_W-1:0] color_rgb,
    input  logic [CHAN_W-1:0]   alpha,
    output logic [PIXEL_W-1:0]  blended_pixel
);

    logic [CHAN_W:0]    inv_alpha;
    logic [PROD_W-1:0]  dprod_reg [4];
    logic [PROD_W-1:0]  dprod_next [4];
    logic [PROD_W-1:0]  cprod_reg [3];
    logic [PROD_W-1:0]  cprod_next [3];
    logic [PIXEL_W-1:0] pixel_reg, pixel_next;
    logic [PROD_W-1:0]  chan_sum;

    assign inv_alpha = ALPHA_ONE - {1'b0, alpha};

    // Lane 3 is the destination alpha, lanes 2 to 0 are red, green, blue.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dprod_next[i] = {{(PROD_W-CHAN_W){1'b0}}, dest_pixel[i*CHAN_W +: CHAN_W]}
                          * {{(PROD_W-CHAN_W-1){1'b0}}, inv_alpha};
        end
        for (int i = 0; i < 3; i++) begin
            cprod_next[i] = {{(PROD_W-CHAN_W){1'b0}}, color_rgb[i*CHAN_W +: CHAN_W]}
                          * {{(PROD_W-CHAN_W){1'b0}}, alpha};
        end
    end

    always_comb begin
        pixel_next[PIXEL_W-1 -: CHAN_W] = dprod_reg[3][PROD_W-1 -: CHAN_W];
        chan_sum = '0;
        for (int i = 0; i < 3; i++) begin
            chan_sum = dprod_reg[i] + cprod_reg[i];
            pixel_next[i*CHAN_W +: CHAN_W] = chan_sum[PROD_W-1 -: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.first) begin
            dprod_reg <= dprod_next;
            cprod_reg <= cprod_next;
        end
        if (en.second) begin
            pixel_reg <= pixel_next;
        end
    end

    assign blended_pixel = pixel_reg;

endmodule

// ----- rtl/coverage_alpha_pixel_blender.sv -----
// Throughput: one beat per cycle; each of the four stages holds its beat
// while the next stage is full and stalled, and fills as soon as it frees.
// Reset clears all stage valid bits, sets mode to body coverage, all zone
// colors to zero and all zone ends to all ones.
module coverage_alpha_pixel_blender
    import cap_pkg::*;
#(
    parameter int unsigned COLOR_ZONES = COLOR_ZONES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // dest_pixel, body_coverage, border_coverage, column, zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // blended_pixel
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned BODY_LSB   = PIXEL_W;
    localparam int unsigned BORDER_LSB = BODY_LSB + COV_W;
    localparam int unsigned COLUMN_LSB = BORDER_LSB + COV_W;

    mode_t                mode;
    logic [PIXEL_W-1:0]   zone_color [COLOR_ZONES];
    logic [PIXEL_W-1:0]   zone_end [COLOR_ZONES];
    logic [PIPE_STAGES-1:0] v_reg, v_next;
    logic [PIPE_STAGES-1:0] stage_en;
    logic [PIXEL_W-1:0]   dest_mid;
    logic [3*CHAN_W-1:0]  rgb_mid;
    logic [CHAN_W-1:0]    alpha_mid;
    cap_stage_en_t        front_en, mix_en;

    always_comb begin
        stage_en[PIPE_STAGES-1] = !v_reg[PIPE_STAGES-1] || m_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !v_reg[k] || stage_en[k+1];
        end
        v_next = v_reg;
        if (stage_en[0]) begin
            v_next[0] = s_tvalid;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (stage_en[k]) begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign front_en = '{first: stage_en[0], second: stage_en[1]};
    assign mix_en   = '{first: stage_en[2], second: stage_en[3]};

    cap_cfg_regs #(
        .COLOR_ZONES (COLOR_ZONES)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mode       (mode),
        .zone_color (zone_color),
        .zone_end   (zone_end)
    );

    cap_front #(
        .COLOR_ZONES (COLOR_ZONES)
    ) u_front (
        .aclk            (aclk),
        .en              (front_en),
        .mode            (mode),
        .zone_color      (zone_color),
        .zone_end        (zone_end),
        .dest_pixel      (s_tdata[PIXEL_W-1:0]),
        .body_coverage   (s_tdata[BODY_LSB +: COV_W]),
        .border_coverage (s_tdata[BORDER_LSB +: COV_W]),
        .column          (s_tdata[COLUMN_LSB +: COLUMN_W]),
        .dest_out        (dest_mid),
        .color_rgb       (rgb_mid),
        .alpha           (alpha_mid)
    );

    cap_mix u_mix (
        .aclk          (aclk),
        .en            (mix_en),
        .dest_pixel    (dest_mid),
        .color_rgb     (rgb_mid),
        .alpha         (alpha_mid),
        .blended_pixel (m_tdata)
    );

    assign s_tready = stage_en[0];
    assign m_tvalid = v_reg[PIPE_STAGES-1];

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (v_reg == '0))
        else $error("Stage valid bits not cleared by reset.");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&v_reg) && !m_tready) |-> !s_tready)
        else $error("Input beat taken while every stage is full and stalled.");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("Input held off without a stalled output beat.");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready && !s_tvalid) |=> !v_reg[0])
        else $error("First stage still valid after draining with no input.");
`endif

endmodule
